// ===== rtl/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and constants of the table sine tone generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int STEP_W   = 32;
  localparam int MAG_W    = 15;
  localparam int ROM_W    = 18;
  localparam int SAMPLE_W = 16;

  localparam logic [MAG_W-1:0] MAG_RESET = 15'd32767;

  // Quarter turn in radians, Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          ROM_FULL    = 131071;

  // Control that travels with a word through the read stage.
  typedef struct packed {
    logic valid;
    logic zero;
  } stage_ctl_t;

endpackage

// ===== rtl/tsg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// tsg_sine_rom
// Full-scale sine table with a registered read port.
// ----------------------------------------------------------------------------
module tsg_sine_rom #(
  parameter int TABLE_LEN = 1024
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [$clog2(TABLE_LEN)-1:0]         rd_addr,
  output logic signed [tsg_pkg::ROM_W-1:0]     rd_data
);

  typedef logic signed [tsg_pkg::ROM_W-1:0] rom_arr_t [TABLE_LEN];

  // sin(pi/2 * num / TABLE_LEN) in Q30 by a truncated Taylor series.
  function automatic logic signed [63:0] quarter_sine(input int unsigned num);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (tsg_pkg::HALF_PI_Q30 * 64'(num)) / TABLE_LEN;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    return sum;
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t           r;
    int unsigned        quad;
    int unsigned        rem;
    int unsigned        num;
    logic signed [63:0] s;
    logic signed [63:0] v;
    for (int i = 0; i < TABLE_LEN; i++) begin
      quad = (4 * i) / TABLE_LEN;
      rem  = (4 * i) % TABLE_LEN;
      num  = (quad % 2 == 1) ? TABLE_LEN - rem : rem;
      s    = quarter_sine(num);
      v    = (s * 64'sd131072 + (64'sd1 <<< 29)) >>> 30;
      if (v > tsg_pkg::ROM_FULL) begin
        v = tsg_pkg::ROM_FULL;
      end
      r[i] = ((quad / 2) % 2 == 1) ? tsg_pkg::ROM_W'(-v) : tsg_pkg::ROM_W'(v);
    end
    return r;
  endfunction

  localparam rom_arr_t ROM_DATA = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ROM_DATA[rd_addr];
    end
  end

endmodule

// ===== rtl/tsg_phase_acc.sv =====
// ----------------------------------------------------------------------------
// tsg_phase_acc
// Phase accumulator and nearest table index of the current phase.
// ----------------------------------------------------------------------------
module tsg_phase_acc #(
  parameter int TABLE_LEN  = 1024,
  parameter int PHASE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             accept,
  input  logic [tsg_pkg::STEP_W-1:0]       step,
  input  logic                             restart,
  output logic [$clog2(TABLE_LEN)-1:0]     index,
  output tsg_pkg::stage_ctl_t              ctl
);

  localparam int IW  = $clog2(TABLE_LEN);
  localparam int TLW = $clog2(TABLE_LEN + 1);
  localparam int EW  = (PHASE_BITS > tsg_pkg::STEP_W) ? PHASE_BITS : tsg_pkg::STEP_W;
  localparam int LSH = (PHASE_BITS >= tsg_pkg::STEP_W) ? PHASE_BITS - tsg_pkg::STEP_W : 0;
  localparam int RSH = (PHASE_BITS < tsg_pkg::STEP_W) ? tsg_pkg::STEP_W - PHASE_BITS : 0;

  logic [PHASE_BITS-1:0]     phase_r, phase_nxt;
  logic [PHASE_BITS-1:0]     phase_cur;
  logic [PHASE_BITS-1:0]     step_al;
  logic [EW-1:0]             step_ext;
  logic [PHASE_BITS+TLW-1:0] prod;
  logic [TLW:0]              half;
  logic [TLW:0]              rnd;
  logic                      zero;
  tsg_pkg::stage_ctl_t       ctl_r, ctl_nxt;

  always_comb begin
    step_ext  = EW'(step);
    step_al   = PHASE_BITS'((step_ext << LSH) >> RSH);
    zero      = (step == '0);
    phase_cur = restart ? '0 : phase_r;
    // Round phase * TABLE_LEN / 2^PHASE_BITS to the nearest index.
    prod      = (PHASE_BITS + TLW)'(phase_cur) * (PHASE_BITS + TLW)'(TABLE_LEN);
    half      = (TLW + 1)'(prod >> (PHASE_BITS - 1));
    rnd       = (half + 1'b1) >> 1;
    index     = (rnd >= (TLW + 1)'(TABLE_LEN)) ? '0 : rnd[IW-1:0];
  end

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = zero ? '0 : phase_cur + step_al;
    end
    ctl_nxt = ctl_r;
    if (adv) begin
      ctl_nxt.valid = accept;
      ctl_nxt.zero  = zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      ctl_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  assign ctl = ctl_r;

  a_zero_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    accept && zero |=> phase_r == '0)
    else $error("phase not cleared after a zero step");

  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    accept && restart && !zero |=> phase_r == $past(step_al))
    else $error("restart did not start the phase from zero");

endmodule

// ===== rtl/tsg_scale.sv =====
// ----------------------------------------------------------------------------
// tsg_scale
// Scales a table value by the magnitude and holds the output word.
// ----------------------------------------------------------------------------
module tsg_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  tsg_pkg::stage_ctl_t                  ctl,
  input  logic signed [tsg_pkg::ROM_W-1:0]     rom_val,
  input  logic [tsg_pkg::MAG_W-1:0]            mag,
  output logic                                 out_valid,
  output logic signed [tsg_pkg::SAMPLE_W-1:0]  out_sample
);

  logic                                valid_r, valid_nxt;
  logic signed [tsg_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [tsg_pkg::MAG_W-1:0]           mag_eff;
  logic [tsg_pkg::ROM_W-2:0]           absv;
  logic [31:0]                         prod;
  logic [tsg_pkg::SAMPLE_W-1:0]        scaled;

  always_comb begin
    mag_eff = (mag == '0) ? tsg_pkg::MAG_W'(1) : mag;
    absv    = rom_val[tsg_pkg::ROM_W-1] ? (tsg_pkg::ROM_W-1)'(-rom_val)
                                        : rom_val[tsg_pkg::ROM_W-2:0];
    // Round half away from zero on the magnitude, then restore the sign.
    prod    = 32'(absv) * 32'(mag_eff) + 32'h0001_0000;
    scaled  = tsg_pkg::SAMPLE_W'(prod >> 17);
    valid_nxt  = valid_r;
    sample_nxt = sample_r;
    if (adv) begin
      valid_nxt = ctl.valid;
      if (ctl.zero) begin
        sample_nxt = '0;
      end else if (rom_val[tsg_pkg::ROM_W-1]) begin
        sample_nxt = -$signed(scaled);
      end else begin
        sample_nxt = $signed(scaled);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    sample_r <= sample_nxt;
  end

  assign out_valid  = valid_r;
  assign out_sample = sample_r;

endmodule

// ===== rtl/table_sine_tone_generator_core.sv =====
// ----------------------------------------------------------------------------
// table_sine_tone_generator_core
// Sine lookup oscillator: phase accumulator, sine table and amplitude scaler.
// ----------------------------------------------------------------------------
// Each input word is one sample tick and yields one output sample. The block
// takes one word per cycle while the output is not stalled. A word passes
// through the phase add and the registered table read into the read stage,
// then through the multiply by the magnitude into the output register. The
// stages follow from the phase accumulator loop and the one read port of the
// sine table. A word is still accepted while a finished sample waits, as long
// as the read stage is free. The table is a constant built at elaboration, so
// no fill pass follows reset.
module table_sine_tone_generator_core #(
  parameter int TABLE_LEN  = 1024,
  parameter int PHASE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tsg_pkg::STEP_W-1:0]           in_tdata,   // [31:0] phase_step
  input  logic                                 in_tuser,   // [0] restart_phase
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic signed [tsg_pkg::SAMPLE_W-1:0]  out_tdata,  // [15:0] sample
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsg_pkg::MAG_W-1:0]            cfg_data    // [14:0] magnitude
);

  logic [tsg_pkg::MAG_W-1:0]           magnitude_r, magnitude_nxt;
  logic                                adv_out;
  logic                                adv_rd;
  logic                                accept;
  logic [$clog2(TABLE_LEN)-1:0]        index;
  logic signed [tsg_pkg::ROM_W-1:0]    rom_val;
  tsg_pkg::stage_ctl_t                 ctl;

  assign adv_out   = !out_tvalid || out_tready;
  assign adv_rd    = !ctl.valid || adv_out;
  assign in_tready = adv_rd;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    magnitude_nxt = magnitude_r;
    if (cfg_valid && cfg_ready) begin
      magnitude_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magnitude_r <= tsg_pkg::MAG_RESET;
    end else begin
      magnitude_r <= magnitude_nxt;
    end
  end

  tsg_phase_acc #(
    .TABLE_LEN  (TABLE_LEN),
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv_rd),
    .accept  (accept),
    .step    (in_tdata),
    .restart (in_tuser),
    .index   (index),
    .ctl     (ctl)
  );

  tsg_sine_rom #(
    .TABLE_LEN (TABLE_LEN)
  ) u_rom (
    .clk     (clk),
    .rd_en   (adv_rd),
    .rd_addr (index),
    .rd_data (rom_val)
  );

  tsg_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv_out),
    .ctl        (ctl),
    .rom_val    (rom_val),
    .mag        (magnitude_r),
    .out_valid  (out_tvalid),
    .out_sample (out_tdata)
  );

  a_zero_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.valid && ctl.zero && adv_out |=> out_tvalid && out_tdata == '0)
    else $error("zero step did not give a silent sample");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.valid |-> in_tready)
    else $error("input stalled with an empty read stage");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && ctl.valid |-> !in_tready)
    else $error("input accepted with both stages full and stalled");

endmodule
